>>> rtl/d2sd_pkg.sv
// Shared constants, state type and lookup functions for the shortest-digits block.
// Holds the 87-entry cached power-of-ten table and the integer powers of ten.
// No dependencies.
package d2sd_pkg;

   localparam int MAX_DIGITS = 18;
   localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
   localparam logic [6:0] CACHE_LAST = 7'd86;
   localparam logic [127:0] ROUND_HALF = 128'h0000_0000_0000_0000_8000_0000_0000_0000;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_NORM = 9'b000000010,
      ST_KMUL = 9'b000000100,
      ST_ROM  = 9'b000001000,
      ST_MUL  = 9'b000010000,
      ST_PREP = 9'b000100000,
      ST_DIV  = 9'b001000000,
      ST_FRAC = 9'b010000000,
      ST_EMIT = 9'b100000000
   } state_type;

   function automatic logic [63:0] pow10(input logic [3:0] n);
      logic [63:0] r;
      case (n)
         4'd0: r = 64'd1;
         4'd1: r = 64'd10;
         4'd2: r = 64'd100;
         4'd3: r = 64'd1000;
         4'd4: r = 64'd10000;
         4'd5: r = 64'd100000;
         4'd6: r = 64'd1000000;
         4'd7: r = 64'd10000000;
         4'd8: r = 64'd100000000;
         4'd9: r = 64'd1000000000;
         default: r = 64'd1;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] pow_mant(input logic [6:0] i);
      logic [63:0] r;
      case (i)
         7'd0: r = 64'd18054884314459144840;
         7'd1: r = 64'd13451937075301367670;
         7'd2: r = 64'd10022474136428063862;
         7'd3: r = 64'd14934650266808366570;
         7'd4: r = 64'd11127181549972568877;
         7'd5: r = 64'd16580792590934885855;
         7'd6: r = 64'd12353653155963782858;
         7'd7: r = 64'd18408377700990114895;
         7'd8: r = 64'd13715310171984221708;
         7'd9: r = 64'd10218702384817765436;
         7'd10: r = 64'd15227053142812498563;
         7'd11: r = 64'd11345038669416679861;
         7'd12: r = 64'd16905424996341287883;
         7'd13: r = 64'd12595523146049147757;
         7'd14: r = 64'd9384396036005875287;
         7'd15: r = 64'd13983839803942852151;
         7'd16: r = 64'd10418772551374772303;
         7'd17: r = 64'd15525180923007089351;
         7'd18: r = 64'd11567161174868858868;
         7'd19: r = 64'd17236413322193710309;
         7'd20: r = 64'd12842128665889583758;
         7'd21: r = 64'd9568131466127621947;
         7'd22: r = 64'd14257626930069360058;
         7'd23: r = 64'd10622759856335341974;
         7'd24: r = 64'd15829145694278690180;
         7'd25: r = 64'd11793632577567316726;
         7'd26: r = 64'd17573882009934360870;
         7'd27: r = 64'd13093562431584567480;
         7'd28: r = 64'd9755464219737475723;
         7'd29: r = 64'd14536774485912137811;
         7'd30: r = 64'd10830740992659433045;
         7'd31: r = 64'd16139061738043178685;
         7'd32: r = 64'd12024538023802026127;
         7'd33: r = 64'd17917957937422433684;
         7'd34: r = 64'd13349918974505688015;
         7'd35: r = 64'd9946464728195732843;
         7'd36: r = 64'd14821387422376473014;
         7'd37: r = 64'd11042794154864902060;
         7'd38: r = 64'd16455045573212060422;
         7'd39: r = 64'd12259964326927110867;
         7'd40: r = 64'd18268770466636286478;
         7'd41: r = 64'd13611294676837538539;
         7'd42: r = 64'd10141204801825835212;
         7'd43: r = 64'd15111572745182864684;
         7'd44: r = 64'd11258999068426240000;
         7'd45: r = 64'd16777216000000000000;
         7'd46: r = 64'd12500000000000000000;
         7'd47: r = 64'd9313225746154785156;
         7'd48: r = 64'd13877787807814456755;
         7'd49: r = 64'd10339757656912845936;
         7'd50: r = 64'd15407439555097886824;
         7'd51: r = 64'd11479437019748901445;
         7'd52: r = 64'd17105694144590052135;
         7'd53: r = 64'd12744735289059618216;
         7'd54: r = 64'd9495567745759798747;
         7'd55: r = 64'd14149498560666738074;
         7'd56: r = 64'd10542197943230523224;
         7'd57: r = 64'd15709099088952724970;
         7'd58: r = 64'd11704190886730495818;
         7'd59: r = 64'd17440603504673385349;
         7'd60: r = 64'd12994262207056124023;
         7'd61: r = 64'd9681479787123295682;
         7'd62: r = 64'd14426529090290212157;
         7'd63: r = 64'd10748601772107342003;
         7'd64: r = 64'd16016664761464807395;
         7'd65: r = 64'd11933345169920330789;
         7'd66: r = 64'd17782069995880619868;
         7'd67: r = 64'd13248674568444952270;
         7'd68: r = 64'd9871031767461413346;
         7'd69: r = 64'd14708983551653345445;
         7'd70: r = 64'd10959046745042015199;
         7'd71: r = 64'd16330252207878254650;
         7'd72: r = 64'd12166986024289022870;
         7'd73: r = 64'd18130221999122236476;
         7'd74: r = 64'd13508068024458167312;
         7'd75: r = 64'd10064294952495520794;
         7'd76: r = 64'd14996968138956309548;
         7'd77: r = 64'd11173611982879273257;
         7'd78: r = 64'd16649979327439178909;
         7'd79: r = 64'd12405201291620119593;
         7'd80: r = 64'd9242595204427927429;
         7'd81: r = 64'd13772540099066387757;
         7'd82: r = 64'd10261342003245940623;
         7'd83: r = 64'd15290591125556738113;
         7'd84: r = 64'd11392378155556871081;
         7'd85: r = 64'd16975966327722178521;
         7'd86: r = 64'd12648080533535911531;
         default: r = 64'd12648080533535911531;
      endcase
      return r;
   endfunction

   function automatic logic signed [11:0] pow_exp(input logic [6:0] i);
      logic signed [11:0] r;
      case (i)
         7'd0: r = -12'sd1220;
         7'd1: r = -12'sd1193;
         7'd2: r = -12'sd1166;
         7'd3: r = -12'sd1140;
         7'd4: r = -12'sd1113;
         7'd5: r = -12'sd1087;
         7'd6: r = -12'sd1060;
         7'd7: r = -12'sd1034;
         7'd8: r = -12'sd1007;
         7'd9: r = -12'sd980;
         7'd10: r = -12'sd954;
         7'd11: r = -12'sd927;
         7'd12: r = -12'sd901;
         7'd13: r = -12'sd874;
         7'd14: r = -12'sd847;
         7'd15: r = -12'sd821;
         7'd16: r = -12'sd794;
         7'd17: r = -12'sd768;
         7'd18: r = -12'sd741;
         7'd19: r = -12'sd715;
         7'd20: r = -12'sd688;
         7'd21: r = -12'sd661;
         7'd22: r = -12'sd635;
         7'd23: r = -12'sd608;
         7'd24: r = -12'sd582;
         7'd25: r = -12'sd555;
         7'd26: r = -12'sd529;
         7'd27: r = -12'sd502;
         7'd28: r = -12'sd475;
         7'd29: r = -12'sd449;
         7'd30: r = -12'sd422;
         7'd31: r = -12'sd396;
         7'd32: r = -12'sd369;
         7'd33: r = -12'sd343;
         7'd34: r = -12'sd316;
         7'd35: r = -12'sd289;
         7'd36: r = -12'sd263;
         7'd37: r = -12'sd236;
         7'd38: r = -12'sd210;
         7'd39: r = -12'sd183;
         7'd40: r = -12'sd157;
         7'd41: r = -12'sd130;
         7'd42: r = -12'sd103;
         7'd43: r = -12'sd77;
         7'd44: r = -12'sd50;
         7'd45: r = -12'sd24;
         7'd46: r = 12'sd3;
         7'd47: r = 12'sd30;
         7'd48: r = 12'sd56;
         7'd49: r = 12'sd83;
         7'd50: r = 12'sd109;
         7'd51: r = 12'sd136;
         7'd52: r = 12'sd162;
         7'd53: r = 12'sd189;
         7'd54: r = 12'sd216;
         7'd55: r = 12'sd242;
         7'd56: r = 12'sd269;
         7'd57: r = 12'sd295;
         7'd58: r = 12'sd322;
         7'd59: r = 12'sd348;
         7'd60: r = 12'sd375;
         7'd61: r = 12'sd402;
         7'd62: r = 12'sd428;
         7'd63: r = 12'sd455;
         7'd64: r = 12'sd481;
         7'd65: r = 12'sd508;
         7'd66: r = 12'sd534;
         7'd67: r = 12'sd561;
         7'd68: r = 12'sd588;
         7'd69: r = 12'sd614;
         7'd70: r = 12'sd641;
         7'd71: r = 12'sd667;
         7'd72: r = 12'sd694;
         7'd73: r = 12'sd720;
         7'd74: r = 12'sd747;
         7'd75: r = 12'sd774;
         7'd76: r = 12'sd800;
         7'd77: r = 12'sd827;
         7'd78: r = 12'sd853;
         7'd79: r = 12'sd880;
         7'd80: r = 12'sd907;
         7'd81: r = 12'sd933;
         7'd82: r = 12'sd960;
         7'd83: r = 12'sd986;
         7'd84: r = 12'sd1013;
         7'd85: r = 12'sd1039;
         7'd86: r = 12'sd1066;
         default: r = 12'sd1066;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/d2sd_mul32.sv
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// Depends on nothing; the sequencer feeds it one partial product a cycle.
module d2sd_mul32 (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] mul_p
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};
   assign mul_p = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> rtl/double_to_shortest_decimal_digits.sv
// Top level of the shortest decimal digits block: sequencer and output register.
// Depends on d2sd_pkg and d2sd_mul32.
//
// One input word yields one to eighteen result words, most significant digit first;
// zero, infinity and NaN yield a single special word. Processing normalizes the
// bounds (bytewise then bitwise), computes the cached-power index, reads the table,
// forms the eight partial products of the two 64x64 scalings through one 32x32
// multiplier, then produces the integer-part digits, up to ten with leading zeros
// included (four restoring subtract steps and one emit step each), and then the
// fraction digits; the emit step waits while the output register cannot take a word.
// The input is ready again once the last word has been loaded into the output
// register and that register can take a new word.
module double_to_shortest_decimal_digits import d2sd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [51:0]        req_fraction,
   input  logic signed [11:0] req_unbiased_exponent,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_digit,
   output logic               rsp_last,
   output logic signed [9:0]  rsp_decimal_exponent,
   output logic               rsp_special
);

   state_type state_ff, state_in;
   logic [63:0] um_ff, um_in, lm_ff, lm_in;
   logic signed [11:0] ue_ff, ue_in, le_ff, le_in;
   logic xneg_ff, xneg_in;
   logic [6:0] idx_ff, idx_in;
   logic [63:0] cmant_ff, cmant_in;
   logic signed [11:0] cexp_ff, cexp_in;
   logic [3:0] mstep_ff, mstep_in;
   logic [127:0] acc_ff, acc_in;
   logic [5:0] s_ff, s_in;
   logic [63:0] mask_ff, mask_in, delta_ff, delta_in, ip_ff, ip_in, dp_ff, dp_in;
   logic signed [10:0] kout_ff, kout_in;
   logic signed [7:0] kappa_ff, kappa_in;
   logic [4:0] len_ff, len_in;
   logic [1:0] bit_ff, bit_in;
   logic [3:0] q_ff, q_in, d_ff, d_in;
   logic stop_ff, stop_in;
   logic rsp_valid_ff, rsp_valid_in, last_ff, last_in, special_ff, special_in;
   logic [3:0] digit_ff, digit_in;
   logic signed [9:0] dexp_ff, dexp_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   logic out_free, is_special, is_sub, closer, emit, fin, lastv;
   logic signed [11:0] e_cl;
   logic signed [12:0] e13, we13, ue13, le13, ce13, sh13, x13, t13, st13;
   logic [12:0] xmag;
   logic [52:0] wm;
   logic [42:0] kround;
   logic [10:0] kmag;
   logic [8:0] ixw;
   logic [5:0] sh6, s6;
   logic [2:0] tag;
   logic [63:0] opx, mask_t, dv, dsub, rem, dp10, dpn, dl10;
   logic [6:0] pshift;
   logic [127:0] addend, acc_new;
   logic signed [10:0] kap11, dsum;

   d2sd_mul32 u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      state_in = state_ff;
      um_in = um_ff;
      lm_in = lm_ff;
      ue_in = ue_ff;
      le_in = le_ff;
      xneg_in = xneg_ff;
      idx_in = idx_ff;
      cmant_in = cmant_ff;
      cexp_in = cexp_ff;
      mstep_in = mstep_ff;
      acc_in = acc_ff;
      s_in = s_ff;
      mask_in = mask_ff;
      delta_in = delta_ff;
      ip_in = ip_ff;
      dp_in = dp_ff;
      kout_in = kout_ff;
      kappa_in = kappa_ff;
      len_in = len_ff;
      bit_in = bit_ff;
      q_in = q_ff;
      d_in = d_ff;
      stop_in = stop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      digit_in = digit_ff;
      last_in = last_ff;
      dexp_in = dexp_ff;
      special_in = special_ff;
      mul_a = 32'd0;
      mul_b = 32'd0;

      e_cl = (req_unbiased_exponent < -12'sd1023) ? -12'sd1023 : req_unbiased_exponent;
      is_special = (e_cl >= 12'sd1024) || ((e_cl == -12'sd1023) && (req_fraction == 52'd0));
      is_sub = (e_cl == -12'sd1023);
      closer = (req_fraction == 52'd0) && (e_cl > -12'sd1022);
      wm = {!is_sub, req_fraction};
      e13 = 13'(e_cl);
      we13 = is_sub ? -13'sd1074 : e13 - 13'sd52;
      ue13 = 13'(ue_ff);
      le13 = 13'(le_ff);
      ce13 = 13'(cexp_ff);
      sh13 = le13 - ue13;
      sh6 = (sh13 < 13'sd0) ? 6'd0 : ((sh13 > 13'sd63) ? 6'd63 : sh13[5:0]);
      x13 = -13'sd61 - ue13;
      xmag = (x13 < 13'sd0) ? 13'(-x13) : 13'(x13);
      kround = mul_p[42:0] + 43'h0FFFFFFFF;
      kmag = xneg_ff ? mul_p[42:32] : kround[42:32];
      t13 = 13'sd347 + (xneg_ff ? -$signed({2'b00, kmag}) : $signed({2'b00, kmag}));
      if (t13 < 13'sd0) begin
         t13 = 13'sd0;
      end
      ixw = {1'b0, t13[10:3]} + 9'd1;
      tag = 3'(mstep_ff - 4'd1);
      opx = mstep_ff[2] ? um_ff : lm_ff;
      case (tag[1:0])
         2'd0: pshift = 7'd0;
         2'd3: pshift = 7'd64;
         default: pshift = 7'd32;
      endcase
      addend = {64'd0, mul_p} << pshift;
      acc_new = ((tag[1:0] == 2'd0) ? ROUND_HALF : acc_ff) + addend;
      st13 = -13'sd64 - ue13 - ce13;
      s6 = (st13 < 13'sd1) ? 6'd1 : ((st13 > 13'sd63) ? 6'd63 : st13[5:0]);
      mask_t = (64'd1 << s6) - 64'd1;
      dv = pow10(4'(kappa_ff[3:0] - 4'd1));
      dsub = dv << bit_ff;
      rem = (ip_ff >= dsub) ? ip_ff - dsub : ip_ff;
      dp10 = (dp_ff << 3) + (dp_ff << 1);
      dpn = dp10 & mask_ff;
      dl10 = (delta_ff << 3) + (delta_ff << 1);
      emit = (d_ff != 4'd0) || (len_ff != 5'd0);
      fin = stop_ff || (kappa_ff <= -8'sd64);
      lastv = fin || (emit && ((len_ff + 5'd1) >= 5'(MAX_DIGITS)));
      kap11 = 11'(kappa_ff);
      dsum = kout_ff + kap11;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (is_special) begin
                  rsp_valid_in = 1'b1;
                  digit_in = 4'd0;
                  last_in = 1'b1;
                  dexp_in = 10'sd0;
                  special_in = 1'b1;
               end else begin
                  um_in = {10'd0, wm, 1'b1};
                  ue_in = 12'(we13 - 13'sd1);
                  if (closer) begin
                     lm_in = {9'd0, wm, 2'b00} - 64'd1;
                     le_in = 12'(we13 - 13'sd2);
                  end else begin
                     lm_in = {10'd0, wm, 1'b0} - 64'd1;
                     le_in = 12'(we13 - 13'sd1);
                  end
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (um_ff[63]) begin
               lm_in = lm_ff << sh6;
               xneg_in = (x13 < 13'sd0);
               mul_a = {19'd0, xmag};
               mul_b = LOG10_2_Q32;
               state_in = ST_KMUL;
            end else if (um_ff[63:56] == 8'd0) begin
               um_in = um_ff << 8;
               ue_in = ue_ff - 12'sd8;
            end else begin
               um_in = um_ff << 1;
               ue_in = ue_ff - 12'sd1;
            end
         end
         ST_KMUL: begin
            idx_in = (ixw > {2'b00, CACHE_LAST}) ? CACHE_LAST : ixw[6:0];
            state_in = ST_ROM;
         end
         ST_ROM: begin
            cmant_in = pow_mant(idx_ff);
            cexp_in = pow_exp(idx_ff);
            mstep_in = 4'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (!mstep_ff[3]) begin
               mul_a = mstep_ff[1] ? opx[63:32] : opx[31:0];
               mul_b = mstep_ff[0] ? cmant_ff[63:32] : cmant_ff[31:0];
            end
            if (mstep_ff != 4'd0) begin
               acc_in = acc_new;
               if (tag[1:0] == 2'd3) begin
                  if (tag[2]) begin
                     um_in = acc_new[127:64] - 64'd1;
                  end else begin
                     lm_in = acc_new[127:64] + 64'd1;
                  end
               end
            end
            mstep_in = mstep_ff + 4'd1;
            if (mstep_ff[3]) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            s_in = s6;
            mask_in = mask_t;
            delta_in = um_ff - lm_ff;
            ip_in = um_ff >> s6;
            dp_in = um_ff & mask_t;
            kout_in = 11'sd348 - $signed({1'b0, idx_ff, 3'b000});
            kappa_in = 8'sd10;
            len_in = 5'd0;
            bit_in = 2'd3;
            q_in = 4'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            ip_in = rem;
            q_in = q_ff | ((ip_ff >= dsub) ? (4'd1 << bit_ff) : 4'd0);
            if (bit_ff == 2'd0) begin
               d_in = q_in;
               kappa_in = kappa_ff - 8'sd1;
               stop_in = ((rem << s_ff) + dp_ff) <= delta_ff;
               state_in = ST_EMIT;
            end else begin
               bit_in = bit_ff - 2'd1;
            end
         end
         ST_FRAC: begin
            d_in = 4'(dp10 >> s_ff);
            dp_in = dpn;
            delta_in = dl10;
            stop_in = dpn <= dl10;
            kappa_in = kappa_ff - 8'sd1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!(emit || fin) || out_free) begin
               if (emit || fin) begin
                  rsp_valid_in = 1'b1;
                  digit_in = d_ff;
                  last_in = lastv;
                  dexp_in = lastv ? dsum[9:0] : 10'sd0;
                  special_in = 1'b0;
               end
               len_in = len_ff + {4'd0, emit};
               if (lastv) begin
                  state_in = ST_IDLE;
               end else if (kappa_ff > 8'sd0) begin
                  bit_in = 2'd3;
                  q_in = 4'd0;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_FRAC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      um_ff <= um_in;
      lm_ff <= lm_in;
      ue_ff <= ue_in;
      le_ff <= le_in;
      xneg_ff <= xneg_in;
      idx_ff <= idx_in;
      cmant_ff <= cmant_in;
      cexp_ff <= cexp_in;
      mstep_ff <= mstep_in;
      acc_ff <= acc_in;
      s_ff <= s_in;
      mask_ff <= mask_in;
      delta_ff <= delta_in;
      ip_ff <= ip_in;
      dp_ff <= dp_in;
      kout_ff <= kout_in;
      kappa_ff <= kappa_in;
      len_ff <= len_in;
      bit_ff <= bit_in;
      q_ff <= q_in;
      d_ff <= d_in;
      stop_ff <= stop_in;
      digit_ff <= digit_in;
      last_ff <= last_in;
      dexp_ff <= dexp_in;
      special_ff <= special_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_digit = digit_ff;
   assign rsp_last = last_ff;
   assign rsp_decimal_exponent = dexp_ff;
   assign rsp_special = special_ff;

   a_special_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_special |-> rsp_last)
      else $error("A special word must be the last word.");

   a_exp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_decimal_exponent == 10'sd0)
      else $error("The exponent must be zero on words other than the last.");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("The input must not be ready while a word is in progress.");

endmodule

>>> tb/tb_double_to_shortest_decimal_digits.sv
// Testbench for double_to_shortest_decimal_digits: random and directed doubles are fed in,
// and every digit word is checked against a built-in shortest-digits predictor.
// Depends on d2sd_pkg and the block's RTL.
`timescale 1ns / 1ps

import d2sd_pkg::*;

typedef struct packed {
   logic [3:0]        digit;
   logic              last;
   logic signed [9:0] dexp;
   logic              special;
} digit_word_type;

class digit_scoreboard;
   digit_word_type pending_words[$];
   int errors;

   function new();
      errors = 0;
   endfunction

   static function logic [63:0] mul_hi_round(logic [63:0] x, logic [63:0] y);
      logic [127:0] prod;
      prod = x * y + 128'h8000_0000_0000_0000;
      return prod[127:64];
   endfunction

   function void note_double(logic [51:0] frac, logic signed [11:0] uexp);
      logic [63:0] wm, um, lm, delta, ip, dp, mask, pw, dg, divisor;
      int e, we, ue, le, sh, kc, idx, s, kout, kappa, len, i;
      longint p;
      logic [3:0] digs[MAX_DIGITS];
      bit stop;
      digit_word_type w;
      e = uexp;
      if (e < -1023) e = -1023;
      if (e >= 1024 || (e == -1023 && frac == 0)) begin
         w = '{4'd0, 1'b1, 10'sd0, 1'b1};
         pending_words.push_back(w);
         return;
      end
      if (e == -1023) begin
         wm = {12'd0, frac};
         we = -1074;
      end else begin
         wm = {12'd1, frac};
         we = e - 52;
      end
      um = (wm << 1) + 1;
      ue = we - 1;
      if (frac == 0 && e > -1022) begin
         lm = (wm << 2) - 1;
         le = we - 2;
      end else begin
         lm = (wm << 1) - 1;
         le = we - 1;
      end
      while (um[63] == 1'b0) begin
         um = um << 1;
         ue--;
      end
      sh = le - ue;
      if (sh < 0) sh = 0;
      if (sh > 63) sh = 63;
      lm = lm << sh;
      p = longint'(-61 - ue) * longint'(LOG10_2_Q32);
      if (p >= 0) kc = int'((p + 64'hFFFF_FFFF) >>> 32);
      else kc = -int'((-p) >>> 32);
      idx = 347 + kc;
      if (idx < 0) idx = 0;
      idx = idx / 8 + 1;
      if (idx > 86) idx = 86;
      pw = pow_mant(idx[6:0]);
      lm = mul_hi_round(lm, pw) + 1;
      um = mul_hi_round(um, pw) - 1;
      s = -(ue + int'(pow_exp(idx[6:0])) + 64);
      if (s < 1) s = 1;
      if (s > 63) s = 63;
      mask = (64'd1 << s) - 1;
      delta = um - lm;
      ip = um >> s;
      dp = um & mask;
      kout = 348 - 8 * idx;
      len = 0;
      kappa = 10;
      divisor = 64'd1000000000;
      forever begin
         if (kappa > 0) begin
            dg = ip / divisor;
            ip = ip % divisor;
            divisor = divisor / 10;
            kappa--;
            stop = ((ip << s) + dp) <= delta;
         end else begin
            dp = dp * 10;
            dg = dp >> s;
            dp = dp & mask;
            kappa--;
            delta = delta * 10;
            stop = dp <= delta;
         end
         if (dg != 0 || len > 0) begin
            digs[len] = dg[3:0];
            len++;
         end
         if (stop || len >= MAX_DIGITS || kappa <= -64) break;
      end
      kout += kappa;
      if (len == 0) begin
         w = '{4'd0, 1'b1, 10'(kout), 1'b0};
         pending_words.push_back(w);
         return;
      end
      for (i = 0; i < len; i++) begin
         w.digit = digs[i];
         w.last = (i == len - 1);
         w.dexp = w.last ? 10'(kout) : 10'sd0;
         w.special = 1'b0;
         pending_words.push_back(w);
      end
   endfunction

   function void check_word(digit_word_type got);
      digit_word_type exp_w;
      if (pending_words.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual %p", $realtime, got);
         errors++;
         return;
      end
      exp_w = pending_words.pop_front();
      if (got.digit !== exp_w.digit) begin
         $display("%0t: digit expected %0d actual %0d", $realtime, exp_w.digit, got.digit);
         errors++;
      end
      if (got.last !== exp_w.last) begin
         $display("%0t: last expected %0d actual %0d", $realtime, exp_w.last, got.last);
         errors++;
      end
      if (got.dexp !== exp_w.dexp) begin
         $display("%0t: exponent expected %0d actual %0d", $realtime, exp_w.dexp, got.dexp);
         errors++;
      end
      if (got.special !== exp_w.special) begin
         $display("%0t: special expected %0d actual %0d", $realtime, exp_w.special,
                  got.special);
         errors++;
      end
   endfunction
endclass

module tb_double_to_shortest_decimal_digits;
   import d2sd_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [51:0]        req_fraction = '0;
   logic signed [11:0] req_unbiased_exponent = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [3:0]         rsp_digit;
   logic               rsp_last;
   logic signed [9:0]  rsp_decimal_exponent;
   logic               rsp_special;

   digit_scoreboard digit_sb = new();
   int unsigned cycle_count = 0;
   int gap_left = 0;
   int burst_left = 0;

   double_to_shortest_decimal_digits dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         digit_sb.check_word('{rsp_digit, rsp_last, rsp_decimal_exponent, rsp_special});
      case ((cycle_count / 300) % 3)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   task automatic send_double(input logic [51:0] frac, input logic signed [11:0] uexp);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
         if (gap_left > 0) req_valid <= 1'b0;
         while (gap_left > 0) begin
            @(posedge clock);
            gap_left--;
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_fraction <= frac;
      req_unbiased_exponent <= uexp;
      do @(posedge clock); while (!req_ready);
      digit_sb.note_double(frac, uexp);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (digit_sb.pending_words.size() != 0);
   endtask

   function automatic logic [51:0] rand_frac();
      logic [51:0] f;
      f = 52'({$urandom, $urandom});
      case ($urandom_range(0, 5))
         0: f = f >> $urandom_range(0, 51);
         1: f = f & ~(52'hF_FFFF_FFFF_FFFF >> $urandom_range(1, 52));
         default: ;
      endcase
      return f;
   endfunction

   initial begin
      int n;
      logic signed [11:0] ex;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_double(52'd0, -12'sd1023);
      send_double(52'd0, 12'sd1024);
      send_double(52'd1, 12'sd1024);
      send_double(52'hF_FFFF_FFFF_FFFF, 12'sd1024);
      send_double(52'd5, 12'sd1500);
      send_double(52'd0, 12'sh800);
      send_double(52'd1, 12'sh800);
      send_double(52'd1, -12'sd1023);
      send_double(52'hF_FFFF_FFFF_FFFF, -12'sd1023);
      send_double(52'h8_0000_0000_0000, -12'sd1023);
      send_double(52'd0, -12'sd1022);
      send_double(52'd0, -12'sd1021);
      send_double(52'd0, 12'sd0);
      send_double(52'h8_0000_0000_0000, 12'sd0);
      send_double(52'h9_9999_9999_999A, -12'sd4);
      send_double(52'h5_5555_5555_5555, -12'sd2);
      send_double(52'hF_FFFF_FFFF_FFFF, 12'sd1023);
      send_double(52'd0, 12'sd1023);
      send_double(52'd0, 12'sd52);
      send_double(52'hF_FFFF_FFFF_FFFF, 12'sd52);
      send_double(52'hA_AAAA_AAAA_AAAA, 12'sd2047);
      wait_drained();
      for (n = 0; n < 230; n++) begin
         case ($urandom_range(0, 9))
            0: ex = 12'($urandom);
            1: ex = -12'sd1023;
            2: ex = 12'($urandom_range(0, 120)) - 12'sd60;
            default: ex = 12'($urandom_range(0, 2046)) - 12'sd1022;
         endcase
         send_double(rand_frac(), ex);
         if (n == 115) wait_drained();
      end
      wait_drained();
      repeat (300) @(posedge clock);
      if (digit_sb.errors == 0 && digit_sb.pending_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

>>> double_to_shortest_decimal_digits.f
rtl/d2sd_pkg.sv
rtl/d2sd_mul32.sv
rtl/double_to_shortest_decimal_digits.sv
tb/tb_double_to_shortest_decimal_digits.sv
